/* rtl/address_range_allocator_top_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the address range allocator
// Clocked on clk, quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_ALLOCATOR_TOP_MACROS_SVH
`define ADDRESS_RANGE_ALLOCATOR_TOP_MACROS_SVH

// property must hold at every edge out of reset
`define ARR_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen
`define ARR_NEVER(lbl, cond, msg) \
  `ARR_CHECK(lbl, !(cond), msg)

`endif

/* rtl/arr_pkg.sv */
// ---------------------------------------------------------------------------
// arr_pkg
// Shared types, status codes and default sizes of the range allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package arr_pkg;

  localparam int MAX_SEGMENTS_D = 256;
  localparam int ADDR_BITS_D    = 40;
  localparam int PAGE_BITS_D    = 12;
  localparam int TAG_BITS_D     = 16;

  // command codes
  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOFIT    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_SHIFT,
    S_PUT,
    S_RESP
  } state_t;

  // piece of a split segment being written
  typedef enum logic [1:0] {
    PC_HEAD,
    PC_MAP,
    PC_TAIL
  } piece_t;

endpackage

`default_nettype wire

/* rtl/arr_if.sv */
// ---------------------------------------------------------------------------
// arr_in_if / arr_out_if
// Valid/ready channels carrying request and result words.
// ---------------------------------------------------------------------------
`default_nettype none

interface arr_in_if
  import arr_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_D,
  parameter int TAG_BITS  = TAG_BITS_D
);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [ADDR_BITS:0]   low_address;
  logic [ADDR_BITS:0]   window_end;
  logic [ADDR_BITS:0]   object_size;
  logic                 from_top;
  logic [TAG_BITS-1:0]  object_tag;

  modport source (output valid, cmd, low_address, window_end, object_size, from_top,
                  object_tag, input ready);
  modport sink   (input valid, cmd, low_address, window_end, object_size, from_top,
                  object_tag, output ready);
endinterface

interface arr_out_if
  import arr_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_D,
  parameter int TAG_BITS  = TAG_BITS_D
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [ADDR_BITS-1:0] placed_address;
  logic [ADDR_BITS:0]   placed_length;
  logic [TAG_BITS-1:0]  released_tag;

  modport source (output valid, status, placed_address, placed_length, released_tag,
                  input ready);
  modport sink   (input valid, status, placed_address, placed_length, released_tag,
                  output ready);
endinterface

`default_nettype wire

/* rtl/address_range_allocator_top.sv */
// ---------------------------------------------------------------------------
// address_range_allocator_top
// First-fit allocator of address ranges in page-rounded windows over a segment table in RAM.
// ---------------------------------------------------------------------------
// The segment table (base, length, mapped flag, owner tag) sits in one
// synchronous RAM of MAX_SEGMENTS entries, kept sorted by base and tiling
// the whole space. After reset the init state writes the single free segment
// covering the space; requests are taken from then on. One request is worked
// at a time. A scan streams one entry per cycle through the RAM read port.
// A successful map then passes a placement step, moves the entries above
// the hit up when the segment is split, and writes the pieces (one to three).
// A finished result waits in the output register; the next request may be
// accepted while it is still pending.
`default_nettype none

module address_range_allocator_top
  import arr_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_D,
  parameter int ADDR_BITS    = ADDR_BITS_D,
  parameter int PAGE_BITS    = PAGE_BITS_D,
  parameter int TAG_BITS     = TAG_BITS_D
) (
  input  wire    clk,
  input  wire    rst_n,
  arr_in_if.sink   in_ch,
  arr_out_if.source out_ch
);

  localparam int AW = ADDR_BITS;
  localparam int LW = AW + 1;
  localparam int XW = AW + 2;
  localparam int TW = TAG_BITS;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = AW + LW + 1 + TW;

  localparam logic [XW-1:0] PG_MASK = XW'((64'(1) << PAGE_BITS) - 64'(1));
  localparam logic [XW-1:0] SPACE   = XW'(64'(1) << AW);

  // segment table
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  state_t        state_r, state_nxt;
  logic [CW-1:0] seg_count_r, seg_count_nxt;

  // request
  logic          cmd_r, cmd_nxt;
  logic [XW-1:0] ws_r, ws_nxt, we_r, we_nxt;
  logic [LW-1:0] size_r, size_nxt, a_r, a_nxt;
  logic          back_r, back_nxt;
  logic [TW-1:0] tag_r, tag_nxt;

  // scan
  logic [CW-1:0] iss_r, iss_nxt;
  logic          ev_v_r, ev_v_nxt;
  logic [IW-1:0] ev_idx_r, ev_idx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;

  // fit and placement
  logic [XW-1:0] sb_r, sb_nxt, se_r, se_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [XW-1:0] ms_r, ms_nxt, me_r, me_nxt;
  logic [1:0]    extra_r, extra_nxt;
  logic          head_r, head_nxt, tail_r, tail_nxt;

  // shift and put
  logic [CW-1:0] sh_src_r, sh_src_nxt, sh_dst_r, sh_dst_nxt;
  logic          sh_pend_r, sh_pend_nxt;
  piece_t        put_ph_r, put_ph_nxt;
  logic [IW-1:0] put_idx_r, put_idx_nxt;

  // result staging and output word
  status_t       res_st_r, res_st_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic [LW-1:0] res_len_r, res_len_nxt;
  logic [TW-1:0] res_tag_r, res_tag_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_st_r, out_st_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt;
  logic [LW-1:0] out_len_r, out_len_nxt;
  logic [TW-1:0] out_tag_r, out_tag_nxt;

  // combinational helpers
  logic          in_fire;
  logic [XW-1:0] in_ws, in_we_raw, in_we;
  logic [AW-1:0] rd_base;
  logic [LW-1:0] rd_len;
  logic          rd_use;
  logic [TW-1:0] rd_owner;
  logic [XW-1:0] f_sb, f_se, f_lo, f_hi, f_span;
  logic          f_fit, hit, scan_done;
  logic [CW-1:0] scan_addr;
  logic [XW-1:0] p_ms, p_me;
  logic [1:0]    p_extra;
  logic          p_full, sh_more, put_last, out_load;
  logic [XW-1:0] d_head, d_tail;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign in_fire            = in_ch.valid && (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.placed_address = out_addr_r;
  assign out_ch.placed_length  = out_len_r;
  assign out_ch.released_tag   = out_tag_r;

  // request window: round to pages, clamp to the space
  assign in_ws     = (XW'(in_ch.low_address) + PG_MASK) & ~PG_MASK;
  assign in_we_raw = XW'(in_ch.window_end) & ~PG_MASK;
  assign in_we     = (in_we_raw > SPACE) ? SPACE : in_we_raw;

  // entry fields
  assign rd_owner = rd_data_r[TW-1:0];
  assign rd_use   = rd_data_r[TW];
  assign rd_len   = rd_data_r[TW+LW:TW+1];
  assign rd_base  = rd_data_r[EW-1:TW+LW+1];

  // fit test of the entry on the read port
  assign f_sb   = XW'(rd_base);
  assign f_se   = f_sb + XW'(rd_len);
  assign f_lo   = (f_sb < ws_r) ? ws_r : f_sb;
  assign f_hi   = (f_se > we_r) ? we_r : f_se;
  assign f_span = f_hi - f_lo;
  assign f_fit  = !rd_use && (f_lo <= f_hi) && (f_span >= XW'(size_r));
  assign hit    = (cmd_r == CMD_UNMAP) ? (rd_use && (XW'(rd_base) == XW'(a_r))) : f_fit;
  assign scan_done = !ev_v_r && (iss_r == seg_count_r);
  assign scan_addr = back_r ? (seg_count_r - CW'(1) - iss_r) : iss_r;

  // placement
  assign p_ms    = back_r ? (hi_r - XW'(size_r)) : lo_r;
  assign p_me    = back_r ? hi_r : (lo_r + XW'(size_r));
  assign p_extra = 2'(p_ms != sb_r) + 2'(p_me != se_r);
  assign p_full  = ((CW+1)'(seg_count_r) + (CW+1)'(p_extra)) > (CW+1)'(MAX_SEGMENTS);

  assign sh_more  = sh_src_r > CW'(hit_idx_r);
  assign put_last = (put_ph_r == PC_TAIL) || ((put_ph_r == PC_MAP) && !tail_r);
  assign out_load = !out_valid_r || out_ch.ready;
  assign d_head   = ms_r - sb_r;
  assign d_tail   = se_r - me_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.cmd == CMD_UNMAP) begin
            state_nxt = S_SCAN;
          end else if ((in_ws >= in_we) || (in_ch.object_size == '0)) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (ev_v_r && hit) begin
          state_nxt = (cmd_r == CMD_UNMAP) ? S_RESP : S_PLACE;
        end else if (scan_done) begin
          state_nxt = S_RESP;
        end
      end
      S_PLACE: begin
        if (p_full) begin
          state_nxt = S_RESP;
        end else if (p_extra == 2'd0) begin
          state_nxt = S_PUT;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: if (!sh_pend_r && !sh_more) state_nxt = S_PUT;
      S_PUT:   if (put_last) state_nxt = S_RESP;
      S_RESP:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    seg_count_nxt = seg_count_r;
    cmd_nxt = cmd_r;  ws_nxt = ws_r;  we_nxt = we_r;  size_nxt = size_r;
    a_nxt = a_r;  back_nxt = back_r;  tag_nxt = tag_r;
    iss_nxt = iss_r;  ev_v_nxt = 1'b0;  ev_idx_nxt = ev_idx_r;  hit_idx_nxt = hit_idx_r;
    sb_nxt = sb_r;  se_nxt = se_r;  lo_nxt = lo_r;  hi_nxt = hi_r;
    ms_nxt = ms_r;  me_nxt = me_r;  extra_nxt = extra_r;  head_nxt = head_r;
    tail_nxt = tail_r;
    sh_src_nxt = sh_src_r;  sh_dst_nxt = sh_dst_r;  sh_pend_nxt = 1'b0;
    put_ph_nxt = put_ph_r;  put_idx_nxt = put_idx_r;
    res_st_nxt = res_st_r;  res_addr_nxt = res_addr_r;  res_len_nxt = res_len_r;
    res_tag_nxt = res_tag_r;
    out_valid_nxt = out_valid_r;  out_st_nxt = out_st_r;  out_addr_nxt = out_addr_r;
    out_len_nxt = out_len_r;  out_tag_nxt = out_tag_r;
    rd_addr = '0;
    wr_en = 1'b0;  wr_addr = '0;  wr_data = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_INIT: begin
        // one free segment over the whole space
        wr_en   = 1'b1;
        wr_data = {AW'(0), LW'(SPACE), 1'b0, TW'(0)};
        seg_count_nxt = CW'(1);
      end
      S_IDLE: begin
        cmd_nxt = in_ch.cmd;  ws_nxt = in_ws;  we_nxt = in_we;
        size_nxt = in_ch.object_size;  a_nxt = in_ch.low_address;
        back_nxt = in_ch.from_top;  tag_nxt = in_ch.object_tag;
        iss_nxt = '0;
        res_addr_nxt = '0;  res_len_nxt = '0;  res_tag_nxt = '0;
        res_st_nxt = (in_ws >= in_we) ? ST_EMPTY : ST_NOFIT;
      end
      S_SCAN: begin
        // stream entries, evaluate each in the cycle after its read
        rd_addr = scan_addr[IW-1:0];
        if (iss_r != seg_count_r) begin
          iss_nxt    = iss_r + CW'(1);
          ev_v_nxt   = 1'b1;
          ev_idx_nxt = scan_addr[IW-1:0];
        end
        if (ev_v_r && hit) begin
          ev_v_nxt    = 1'b0;
          hit_idx_nxt = ev_idx_r;
          sb_nxt = f_sb;  se_nxt = f_se;  lo_nxt = f_lo;  hi_nxt = f_hi;
          if (cmd_r == CMD_UNMAP) begin
            wr_en   = 1'b1;
            wr_addr = ev_idx_r;
            wr_data = {rd_base, rd_len, 1'b0, TW'(0)};
            res_st_nxt = ST_OK;  res_addr_nxt = rd_base;  res_len_nxt = rd_len;
            res_tag_nxt = rd_owner;
          end
        end else if (scan_done) begin
          res_st_nxt = (cmd_r == CMD_UNMAP) ? ST_NOTFOUND : ST_NOFIT;
        end
      end
      S_PLACE: begin
        ms_nxt = p_ms;  me_nxt = p_me;  extra_nxt = p_extra;
        head_nxt = (p_ms != sb_r);  tail_nxt = (p_me != se_r);
        sh_src_nxt = seg_count_r - CW'(1);
        put_idx_nxt = hit_idx_r;
        put_ph_nxt = (p_ms != sb_r) ? PC_HEAD : PC_MAP;
        if (p_full) res_st_nxt = ST_FULL;
      end
      S_SHIFT: begin
        // move the entries above the hit up, top first
        if (sh_pend_r) begin
          wr_en = 1'b1;  wr_addr = sh_dst_r[IW-1:0];  wr_data = rd_data_r;
        end
        rd_addr = sh_src_r[IW-1:0];
        if (sh_more) begin
          sh_pend_nxt = 1'b1;
          sh_dst_nxt  = sh_src_r + CW'(extra_r);
          sh_src_nxt  = sh_src_r - CW'(1);
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = put_idx_r;
        put_idx_nxt = put_idx_r + IW'(1);
        case (put_ph_r)
          PC_HEAD: begin
            wr_data = {sb_r[AW-1:0], d_head[LW-1:0], 1'b0, TW'(0)};
            put_ph_nxt = PC_MAP;
          end
          PC_MAP: begin
            wr_data = {ms_r[AW-1:0], size_r, 1'b1, tag_r};
            put_ph_nxt = PC_TAIL;
          end
          PC_TAIL: wr_data = {me_r[AW-1:0], d_tail[LW-1:0], 1'b0, TW'(0)};
          default: wr_data = '0;
        endcase
        if (put_last) begin
          seg_count_nxt = seg_count_r + CW'(extra_r);
          res_st_nxt = ST_OK;  res_addr_nxt = ms_r[AW-1:0];  res_len_nxt = size_r;
          res_tag_nxt = '0;
        end
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_st_nxt = res_st_r;  out_addr_nxt = res_addr_r;  out_len_nxt = res_len_r;
          out_tag_nxt = res_tag_r;
        end
      end
      default: ;
    endcase
  end

  // table RAM
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      seg_count_r <= CW'(1);
      ev_v_r      <= 1'b0;
      sh_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seg_count_r <= seg_count_nxt;
      ev_v_r      <= ev_v_nxt;
      sh_pend_r   <= sh_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;  ws_r <= ws_nxt;  we_r <= we_nxt;  size_r <= size_nxt;
    a_r <= a_nxt;  back_r <= back_nxt;  tag_r <= tag_nxt;
    iss_r <= iss_nxt;  ev_idx_r <= ev_idx_nxt;  hit_idx_r <= hit_idx_nxt;
    sb_r <= sb_nxt;  se_r <= se_nxt;  lo_r <= lo_nxt;  hi_r <= hi_nxt;
    ms_r <= ms_nxt;  me_r <= me_nxt;  extra_r <= extra_nxt;
    head_r <= head_nxt;  tail_r <= tail_nxt;
    sh_src_r <= sh_src_nxt;  sh_dst_r <= sh_dst_nxt;
    put_ph_r <= put_ph_nxt;  put_idx_r <= put_idx_nxt;
    res_st_r <= res_st_nxt;  res_addr_r <= res_addr_nxt;  res_len_r <= res_len_nxt;
    res_tag_r <= res_tag_nxt;
    out_st_r <= out_st_nxt;  out_addr_r <= out_addr_nxt;  out_len_r <= out_len_nxt;
    out_tag_r <= out_tag_nxt;
  end

`include "address_range_allocator_top_macros.svh"

  `ARR_CHECK(a_count_range, (seg_count_r != '0) && (seg_count_r <= CW'(MAX_SEGMENTS)), "segment count out of range")
  `ARR_CHECK(a_scan_idx, ev_v_r |-> (CW'(ev_idx_r) < seg_count_r), "scan evaluates an unused entry")
  `ARR_NEVER(a_shift_dst, (state_r == S_SHIFT) && sh_pend_r && (sh_dst_r <= CW'(hit_idx_r)), "shift overwrites the hit segment")
  `ARR_CHECK(a_head_flag, (state_r == S_PUT && put_ph_r == PC_HEAD) |-> head_r, "head piece written without a head gap")

endmodule

`default_nettype wire

/* tb/address_range_allocator_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// address_range_allocator_checker
// Watches the request and result channels and keeps its own copy of the
// segment table. Each accepted request is worked through that copy and the
// outcome queued. Each accepted result word is compared with the oldest entry.
// ---------------------------------------------------------------------------

module address_range_allocator_checker
  import arr_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  arr_in_if    in_ch,
  arr_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   n_map_ok,
  output int   n_unmap_ok,
  output int   n_full,
  output int   n_refused
);

  localparam logic [63:0] SPACE     = 64'd1 << ADDR_BITS_D;
  localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_BITS_D) - 64'd1;

  typedef struct packed {
    status_t      st;
    logic [39:0]  addr;
    logic [40:0]  len;
    logic [15:0]  tag;
  } alloc_result_t;

  // shadow segment table
  logic [63:0] seg_base  [MAX_SEGMENTS_D];
  logic [63:0] seg_len   [MAX_SEGMENTS_D];
  logic        seg_used  [MAX_SEGMENTS_D];
  logic [15:0] seg_owner [MAX_SEGMENTS_D];
  int          seg_count;

  alloc_result_t expected_results[$];

  function automatic void put_segment(int i, logic [63:0] b, logic [63:0] l, logic u,
                                      logic [15:0] t);
    seg_base[i]  = b;
    seg_len[i]   = l;
    seg_used[i]  = u;
    seg_owner[i] = t;
  endfunction

  // work one request through the shadow table
  function automatic alloc_result_t work_request(logic cmd, logic [40:0] la,
                                                 logic [40:0] wend, logic [40:0] sz_in,
                                                 logic back, logic [15:0] tg);
    alloc_result_t r;
    logic [63:0] ws, we, sz, lo, hi, cs, ce, ms, me, sb, se;
    int hit, idx, pieces, k;
    r = '0;
    r.st = ST_OK;
    hit = -1;
    lo = 0;
    hi = 0;
    if (cmd == CMD_UNMAP) begin
      for (int i = 0; i < seg_count; i++) begin
        if (seg_base[i] == {23'd0, la} && seg_used[i]) begin
          hit = i;
          break;
        end
      end
      if (hit < 0) begin
        r.st = ST_NOTFOUND;
      end else begin
        r.addr = seg_base[hit][39:0];
        r.len  = seg_len[hit][40:0];
        r.tag  = seg_owner[hit];
        seg_used[hit]  = 1'b0;
        seg_owner[hit] = '0;
      end
      return r;
    end
    ws = ({23'd0, la} + PAGE_MASK) & ~PAGE_MASK;
    we = {23'd0, wend} & ~PAGE_MASK;
    sz = {23'd0, sz_in};
    if (we > SPACE) we = SPACE;
    if (ws >= we) begin
      r.st = ST_EMPTY;
      return r;
    end
    if (sz == 0) begin
      r.st = ST_NOFIT;
      return r;
    end
    // first fit, from either end
    for (int j = 0; j < seg_count; j++) begin
      idx = back ? seg_count - 1 - j : j;
      if (!seg_used[idx]) begin
        cs = seg_base[idx];
        ce = seg_base[idx] + seg_len[idx];
        if (cs < ws) cs = ws;
        if (ce > we) ce = we;
        if (!(cs > ce || ce - cs < sz)) begin
          hit = idx;
          lo = cs;
          hi = ce;
          break;
        end
      end
    end
    if (hit < 0) begin
      r.st = ST_NOFIT;
      return r;
    end
    ms = back ? hi - sz : lo;
    me = ms + sz;
    sb = seg_base[hit];
    se = sb + seg_len[hit];
    pieces = 1 + (ms != sb) + (me != se);
    if (seg_count + pieces - 1 > MAX_SEGMENTS_D) begin
      r.st = ST_FULL;
      return r;
    end
    // open a hole above the hit for the extra pieces
    for (int j = seg_count - 1; j > hit; j--) begin
      put_segment(j + pieces - 1, seg_base[j], seg_len[j], seg_used[j], seg_owner[j]);
    end
    seg_count += pieces - 1;
    k = hit;
    if (ms != sb) begin
      put_segment(k, sb, ms - sb, 1'b0, '0);
      k++;
    end
    put_segment(k, ms, sz, 1'b1, tg);
    k++;
    if (me != se) put_segment(k, me, se - me, 1'b0, '0);
    r.addr = ms[39:0];
    r.len  = sz[40:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t e, got;
    if (!rst_n) begin
      for (int i = 0; i < MAX_SEGMENTS_D; i++) put_segment(i, '0, '0, 1'b0, '0);
      seg_len[0] = SPACE;
      seg_count = 1;
      expected_results.delete();
      fail_count <= 0;
      n_map_ok <= 0;
      n_unmap_ok <= 0;
      n_full <= 0;
      n_refused <= 0;
    end else begin
      // result side first: a word accepted now came from an earlier request
      if (out_ch.valid && out_ch.ready) begin
        got.st   = status_t'(out_ch.status);
        got.addr = out_ch.placed_address;
        got.len  = out_ch.placed_length;
        got.tag  = out_ch.released_tag;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result word st=%0d addr=%h len=%h tag=%h",
                     $realtime, got.st, got.addr, got.len, got.tag);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (e !== got) begin
            if (fail_count < 10)
              $display("%0t: mismatch exp st=%0d addr=%h len=%h tag=%h got st=%0d addr=%h len=%h tag=%h",
                       $realtime, e.st, e.addr, e.len, e.tag,
                       got.st, got.addr, got.len, got.tag);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        e = work_request(in_ch.cmd, in_ch.low_address, in_ch.window_end, in_ch.object_size,
                         in_ch.from_top, in_ch.object_tag);
        expected_results.push_back(e);
        if (e.st == ST_OK && in_ch.cmd == CMD_MAP) n_map_ok <= n_map_ok + 1;
        else if (e.st == ST_OK) n_unmap_ok <= n_unmap_ok + 1;
        else if (e.st == ST_FULL) n_full <= n_full + 1;
        else n_refused <= n_refused + 1;
      end
    end
  end

endmodule

/* tb/address_range_allocator_top_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// address_range_allocator_top_test
// Drives map and unmap requests into the allocator with random gaps and
// back-pressure; a separate checker predicts and compares each result word.
// ---------------------------------------------------------------------------

module address_range_allocator_top_test;
  import arr_pkg::*;

  localparam int          N_RANDOM   = 1030;
  localparam int          IDLE_PCT   = 28;
  localparam int          STALL_MAX  = 20000;
  localparam logic [40:0] SPACE      = 41'd1 << ADDR_BITS_D;

  logic clk;
  logic rst_n;
  logic no_idle;
  int   fail_count, pending, n_map_ok, n_unmap_ok, n_full, n_refused;
  int   stall_cycles;
  logic [39:0] mapped_starts[$];

  arr_in_if  in_ch ();
  arr_out_if out_ch ();

  address_range_allocator_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  address_range_allocator_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .n_map_ok   (n_map_ok),
    .n_unmap_ok (n_unmap_ok),
    .n_full     (n_full),
    .n_refused  (n_refused)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ch.ready <= rst_n && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
  end

  // collect starts of mapped ranges for later unmaps
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && out_ch.status == ST_OK &&
        out_ch.released_tag == '0)
      mapped_starts.push_back(out_ch.placed_address);
  end

  // watchdog: cycles in which no word moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("address_range_allocator_top_test: errors");
      $finish;
    end
  end

  function automatic logic [40:0] rand41();
    return 41'({$urandom, $urandom});
  endfunction

  // one request word; valid stays high across back-to-back words
  task automatic send_word(logic cmd, logic [40:0] la, logic [40:0] wend,
                           logic [40:0] sz, logic back, logic [15:0] tg);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.low_address <= la;
    in_ch.window_end  <= wend;
    in_ch.object_size <= sz;
    in_ch.from_top    <= back;
    in_ch.object_tag  <= tg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_map(logic [40:0] la, logic [40:0] wend, logic [40:0] sz,
                          logic back, logic [15:0] tg);
    send_word(CMD_MAP, la, wend, sz, back, tg);
  endtask

  task automatic send_unmap(logic [40:0] la);
    send_word(CMD_UNMAP, la, rand41(), rand41(), 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  initial begin
    logic [40:0] la, wend, sz;
    int pick;
    rst_n             <= 1'b0;
    no_idle           <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_MAP;
    in_ch.low_address <= '0;
    in_ch.window_end  <= '0;
    in_ch.object_size <= '0;
    in_ch.from_top    <= 1'b0;
    in_ch.object_tag  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: whole space, release, edges and refusals
    send_map(41'd0, SPACE, SPACE, 1'b0, 16'hffff);
    send_unmap(41'd0);
    send_unmap(41'd0);
    send_map(41'd0, SPACE, SPACE + 41'd1, 1'b0, 16'h1);
    send_map(41'd0, SPACE, 41'd0, 1'b0, 16'h2);
    send_map(41'h1001, 41'h1fff, 41'd1, 1'b0, 16'h3);
    send_map(41'h5000, 41'h3000, 41'd1, 1'b1, 16'h4);
    send_map(41'h1ff_ffff_ffff, 41'h1ff_ffff_ffff, 41'd1, 1'b0, 16'h5);
    send_map(41'd1, 41'h1ff_ffff_ffff, 41'd1, 1'b1, 16'hffff);
    send_map(41'd0, 41'h1ff_ffff_ffff, 41'h1000, 1'b0, 16'h0);
    send_map(41'h10_0000, 41'h20_0000, 41'h1234, 1'b0, 16'ha5a5);
    send_map(41'h10_0000, 41'h20_0000, 41'h1234, 1'b1, 16'h5a5a);
    send_map(41'h10_0000, 41'h20_0000, 41'h10_0000, 1'b0, 16'h6);
    send_unmap(41'h10_0001);
    send_unmap(SPACE);
    send_unmap(41'h1ff_ffff_f000);
    send_unmap(41'h1000);
    send_map(41'd0, 41'h1000, 41'h1000, 1'b0, 16'h7);
    send_unmap(41'h0);
    in_ch.valid <= 1'b0;
    // hold off until every result is back
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // random: mostly small maps and unmaps of live ranges
    for (int n = 0; n < N_RANDOM; n++) begin
      no_idle <= (n >= 300 && n < 450);
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        if (mapped_starts.size() > 0 && $urandom_range(0, 9) < 8) begin
          la = {1'b0, mapped_starts[$urandom_range(0, mapped_starts.size() - 1)]};
          send_unmap(la);
        end else begin
          if ($urandom_range(0, 1) != 0)
            la = rand41();
          else
            la = 41'({$urandom_range(0, 1023), 12'h000});
          send_unmap(la);
        end
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            la = 41'd0;
            wend = SPACE;
          end
          1: begin
            la = rand41();
            wend = rand41();
          end
          default: begin
            la = 41'({$urandom_range(0, 255), 20'h00000}) + 41'($urandom_range(0, 4095));
            wend = la + 41'({$urandom_range(1, 64), 16'h0000});
          end
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 15) sz = 41'($urandom_range(1, 1 << 18));
        else if (pick < 17) sz = 41'({$urandom_range(1, 64), 12'h000});
        else if (pick < 19) sz = rand41();
        else sz = 41'd0;
        send_map(la, wend, sz, 1'($urandom_range(0, 1)), 16'($urandom));
      end
    end
    in_ch.valid <= 1'b0;
    no_idle <= 1'b0;

    // drain, then give the block time to show any stray word
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("requests: %0d maps placed, %0d ranges released, %0d table-full, %0d refused",
             n_map_ok, n_unmap_ok, n_full, n_refused);
    if (fail_count == 0)
      $display("address_range_allocator_top_test: clean");
    else
      $display("address_range_allocator_top_test: errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/arr_pkg.sv
rtl/arr_if.sv
rtl/address_range_allocator_top.sv
tb/address_range_allocator_checker.sv
tb/address_range_allocator_top_test.sv
